FILE: hdl/srrw_pkg.sv
// Package for the selective-repeat receive window.
// Word types of both channels, field widths, result kinds and controller states.
// No dependencies.
package srrw_pkg;

    localparam int SEQ_W     = 16;
    localparam int CHECK_W   = 18;
    localparam int ACKCHK_W  = 17;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 32;
    localparam int PAYLOAD_W = LOW_W + LOW_W + HIGH_W;
    localparam int PSUM_W    = 19;
    localparam int SUM_W     = 20;

    localparam int WINDOW_SLOTS_DEF = 16;
    localparam int SEQ_BITS_DEF     = 16;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq_number;
        logic [SEQ_W-1:0]   ack_number;
        logic [CHECK_W-1:0] packet_check;
        logic [LOW_W-1:0]   payload_low;
        logic [LOW_W-1:0]   payload_mid;
        logic [HIGH_W-1:0]  payload_high;
    } pkt_word_t;

    typedef struct packed {
        logic                result_kind;
        logic [SEQ_W-1:0]    result_seq;
        logic [ACKCHK_W-1:0] ack_check;
        logic [LOW_W-1:0]    data_low;
        logic [LOW_W-1:0]    data_mid;
        logic [HIGH_W-1:0]   data_high;
        logic                last_of_run;
    } res_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FOLD,
        ST_CHECK,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

FILE: hdl/srrw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read. No dependencies.
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/selective_repeat_receive_window.sv
// A packet holds the input from its accept cycle through ST_SUM and ST_FOLD, which
// form the ones' complement payload checksum, and ST_CHECK, which compares the check
// value, classifies the window distance, stores the payload and registers the ack.
// An in-order packet then delivers the run of consecutive stored slots, each slot
// through ST_READ and then ST_EMIT, set by the single read port of the payload RAM
// (read, then load the result register); such a packet holds the input until the
// run ends. A stalled result register holds ST_CHECK or ST_EMIT. Packets with a bad
// check or beyond the window end give no result. Slot valid bits reset with the
// block, so no clearing pass is needed.
//
// Depends on srrw_pkg and srrw_ram.
module selective_repeat_receive_window #(
    parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = srrw_pkg::SEQ_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_stall,
    input  srrw_pkg::pkt_word_t pkt_word,
    output logic                res_valid,
    input  logic                res_stall,
    output srrw_pkg::res_word_t res_word
);

    localparam int SLOT_BITS = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int SW        = SLOT_BITS + 2;
    localparam int TWO_W     = 2 * WINDOW_SLOTS;
    // slot offset owed when the sequence number wraps past 2^SEQ_BITS
    localparam int WRAP_ADJ  = WINDOW_SLOTS
                             - int'((64'd1 << SEQ_BITS) % 64'(WINDOW_SLOTS));

    srrw_pkg::state_t state_reg, state_next;

    srrw_pkg::pkt_word_t              pkt_reg, pkt_next;
    logic [srrw_pkg::PSUM_W-1:0]      sum_a_reg, sum_a_next;
    logic [srrw_pkg::PSUM_W-1:0]      sum_b_reg, sum_b_next;
    logic [srrw_pkg::SEQ_W-1:0]       csum_reg, csum_next;
    logic [SEQ_BITS-1:0]              ne_reg, ne_next;
    logic [SLOT_BITS-1:0]             nslot_reg, nslot_next;
    logic [WINDOW_SLOTS-1:0]          valid_reg, valid_next;
    logic                             res_valid_reg, res_valid_next;
    srrw_pkg::res_word_t              res_word_reg, res_word_next;

    logic                             res_free;
    logic [SEQ_BITS-1:0]              seq_s;
    logic [SEQ_BITS-1:0]              seq_dist;
    logic                             in_window;
    logic                             behind;
    logic                             match;
    logic [srrw_pkg::CHECK_W-1:0]     total;
    logic                             wrap;
    logic [SW-1:0]                    slot_sum;
    logic [SLOT_BITS-1:0]             pslot;
    logic [SLOT_BITS-1:0]             nslot_inc;
    logic [WINDOW_SLOTS-1:0]          valid_clr;
    logic                             run_last;
    logic [srrw_pkg::SUM_W-1:0]       fsum;
    logic [16:0]                      fold1;
    logic [15:0]                      fold2;

    logic                             ram_we;
    logic                             ram_re;
    logic [srrw_pkg::PAYLOAD_W-1:0]   ram_wdata;
    logic [srrw_pkg::PAYLOAD_W-1:0]   ram_rdata;

    srrw_ram #(
        .WIDTH (srrw_pkg::PAYLOAD_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pslot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (nslot_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {pkt_reg.payload_high, pkt_reg.payload_mid, pkt_reg.payload_low};

    // ---------------- datapath ----------------
    assign res_free = !res_valid_reg || !res_stall;

    assign seq_s     = SEQ_BITS'(32'(pkt_reg.seq_number));
    assign seq_dist  = seq_s - ne_reg;
    assign in_window = 32'(seq_dist) < 32'(WINDOW_SLOTS);
    assign behind    = seq_dist[SEQ_BITS-1];
    assign total     = srrw_pkg::CHECK_W'(csum_reg) + srrw_pkg::CHECK_W'(pkt_reg.ack_number)
                     + srrw_pkg::CHECK_W'(pkt_reg.seq_number);
    assign match     = total == pkt_reg.packet_check;

    // slot = seq mod W, formed from the tracked slot of next_expected
    assign wrap     = seq_s < ne_reg;
    assign slot_sum = SW'(nslot_reg) + SW'(32'(seq_dist)) + (wrap ? SW'(WRAP_ADJ) : SW'(0));

    always_comb
    begin
        if (slot_sum >= SW'(TWO_W))
        begin
            pslot = SLOT_BITS'(slot_sum - SW'(TWO_W));
        end
        else if (slot_sum >= SW'(WINDOW_SLOTS))
        begin
            pslot = SLOT_BITS'(slot_sum - SW'(WINDOW_SLOTS));
        end
        else
        begin
            pslot = SLOT_BITS'(slot_sum);
        end
    end

    assign nslot_inc = ((nslot_reg == SLOT_BITS'(WINDOW_SLOTS - 1)) || (ne_reg == '1))
                     ? '0 : nslot_reg + 1'b1;
    assign valid_clr = valid_reg & ~(WINDOW_SLOTS'(1) << nslot_reg);
    assign run_last  = !valid_clr[nslot_inc];

    assign fsum  = srrw_pkg::SUM_W'(sum_a_reg) + srrw_pkg::SUM_W'(sum_b_reg);
    assign fold1 = 17'(fsum[15:0]) + 17'(fsum[19:16]);
    // the second fold cannot carry out of 16 bits
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srrw_pkg::ST_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = srrw_pkg::ST_SUM;
                end
            end
            srrw_pkg::ST_SUM:
            begin
                state_next = srrw_pkg::ST_FOLD;
            end
            srrw_pkg::ST_FOLD:
            begin
                state_next = srrw_pkg::ST_CHECK;
            end
            srrw_pkg::ST_CHECK:
            begin
                if (!match || !(in_window || behind))
                begin
                    state_next = srrw_pkg::ST_IDLE;
                end
                else if (res_free)
                begin
                    state_next = (in_window && seq_dist == '0) ? srrw_pkg::ST_READ
                                                               : srrw_pkg::ST_IDLE;
                end
            end
            srrw_pkg::ST_READ:
            begin
                state_next = srrw_pkg::ST_EMIT;
            end
            srrw_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = run_last ? srrw_pkg::ST_IDLE : srrw_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and register updates ----------------
    always_comb
    begin
        pkt_next       = pkt_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        csum_next      = csum_reg;
        ne_next        = ne_reg;
        nslot_next     = nslot_reg;
        valid_next     = valid_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        pkt_stall      = 1'b1;
        case (state_reg)
            srrw_pkg::ST_IDLE:
            begin
                pkt_stall = 1'b0;
                if (pkt_valid)
                begin
                    pkt_next = pkt_word;
                end
            end
            srrw_pkg::ST_SUM:
            begin
                sum_a_next = srrw_pkg::PSUM_W'(pkt_reg.payload_low[15:0])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_low[31:16])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_low[47:32])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_low[63:48])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_mid[15:0]);
                sum_b_next = srrw_pkg::PSUM_W'(pkt_reg.payload_mid[31:16])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_mid[47:32])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_mid[63:48])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_high[15:0])
                           + srrw_pkg::PSUM_W'(pkt_reg.payload_high[31:16]);
            end
            srrw_pkg::ST_FOLD:
            begin
                csum_next = ~fold2;
            end
            srrw_pkg::ST_CHECK:
            begin
                if (match && (in_window || behind) && res_free)
                begin
                    res_valid_next            = 1'b1;
                    res_word_next             = '0;
                    res_word_next.result_kind = srrw_pkg::KIND_ACK;
                    res_word_next.result_seq  = pkt_reg.seq_number;
                    res_word_next.ack_check   = {pkt_reg.seq_number, 1'b0};
                    res_word_next.last_of_run = !(in_window && seq_dist == '0);
                    if (in_window)
                    begin
                        ram_we            = 1'b1;
                        valid_next[pslot] = 1'b1;
                    end
                end
            end
            srrw_pkg::ST_READ:
            begin
                ram_re = 1'b1;
            end
            srrw_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next            = 1'b1;
                    res_word_next.result_kind = srrw_pkg::KIND_DELIVER;
                    res_word_next.result_seq  = srrw_pkg::SEQ_W'(32'(ne_reg));
                    res_word_next.ack_check   = '0;
                    res_word_next.data_low    = ram_rdata[srrw_pkg::LOW_W-1:0];
                    res_word_next.data_mid    = ram_rdata[2*srrw_pkg::LOW_W-1:srrw_pkg::LOW_W];
                    res_word_next.data_high   = ram_rdata[srrw_pkg::PAYLOAD_W-1:2*srrw_pkg::LOW_W];
                    res_word_next.last_of_run = run_last;
                    valid_next                = valid_clr;
                    ne_next                   = ne_reg + 1'b1;
                    nslot_next                = nslot_inc;
                end
            end
            default:
            begin
                pkt_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srrw_pkg::ST_IDLE;
            ne_reg        <= '0;
            nslot_reg     <= '0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            nslot_reg     <= nslot_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg      <= pkt_next;
        sum_a_reg    <= sum_a_next;
        sum_b_reg    <= sum_b_next;
        csum_reg     <= csum_next;
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

FILE: hdl/srrw_check.sv
// Port-level checker for the selective-repeat receive window, bound to the top.
// Depends on srrw_pkg.
module srrw_check (
    input logic                clk,
    input logic                rst_n,
    input logic                pkt_valid,
    input logic                pkt_stall,
    input srrw_pkg::pkt_word_t pkt_word,
    input logic                res_valid,
    input logic                res_stall,
    input srrw_pkg::res_word_t res_word
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed under stall");

    // one packet at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_stall |=> pkt_stall)
        else $error("second packet taken while busy");

    // ack words carry twice the seq and no data
    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.result_kind == srrw_pkg::KIND_ACK |->
            res_word.ack_check == {res_word.result_seq, 1'b0}
            && res_word.data_low == '0 && res_word.data_mid == '0
            && res_word.data_high == '0)
        else $error("malformed ack word");

    // delivery words carry a zero ack check
    a_dlv_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.result_kind == srrw_pkg::KIND_DELIVER |->
            res_word.ack_check == '0)
        else $error("delivery word with nonzero ack check");

    // the idle block takes no time to accept: stall never rises without an accept
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_stall && !pkt_valid |=> !pkt_stall)
        else $error("busy without an accepted packet");

endmodule

bind selective_repeat_receive_window srrw_check u_srrw_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_word  (pkt_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);

FILE: verif/selective_repeat_receive_window_tb.sv
`timescale 1ns / 100ps
// Testbench for selective_repeat_receive_window: directed window cases, then random packets.
// Results are predicted in-line and checked field by field.
// Depends on srrw_pkg and the RTL of the block.
module testbench;

    localparam int WIN        = srrw_pkg::WINDOW_SLOTS_DEF;
    localparam int RUN_ITEMS  = 200;
    localparam int DRAIN_WAIT = 64;
    localparam int MAX_CYCLES = 200000;

    logic                clk;
    logic                rst_n;
    logic                pkt_valid;
    logic                pkt_stall;
    srrw_pkg::pkt_word_t pkt_word;
    logic                res_valid;
    logic                res_stall = 1'b0;
    srrw_pkg::res_word_t res_word;

    // receiver model state
    logic [srrw_pkg::SEQ_W-1:0]  window_base;
    logic                        slot_full [WIN];
    logic [srrw_pkg::LOW_W-1:0]  slot_low  [WIN];
    logic [srrw_pkg::LOW_W-1:0]  slot_mid  [WIN];
    logic [srrw_pkg::HIGH_W-1:0] slot_high [WIN];

    srrw_pkg::res_word_t expected_results[$];
    srrw_pkg::res_word_t want;
    logic                no_idle;
    int                  errors = 0;
    int                  cycles = 0;
    int                  n_pkts, n_acks, n_deliv, n_drop, n_bad;

    selective_repeat_receive_window u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_word  (pkt_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** selective_repeat_receive_window: FAILED **");
            $finish;
        end
    end

    // ones' complement payload checksum plus ack and seq, as plain integers
    function automatic logic [srrw_pkg::CHECK_W-1:0] pkt_total(srrw_pkg::pkt_word_t w);
        logic [19:0] acc;
        logic [15:0] csum;
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc += w.payload_low[16*i +: 16];
            acc += w.payload_mid[16*i +: 16];
        end
        for (int i = 0; i < 2; i++)
            acc += w.payload_high[16*i +: 16];
        acc  = acc[15:0] + acc[19:16];
        acc  = acc[15:0] + acc[19:16];
        csum = ~acc[15:0];
        return srrw_pkg::CHECK_W'(csum) + srrw_pkg::CHECK_W'(w.ack_number)
             + srrw_pkg::CHECK_W'(w.seq_number);
    endfunction

    function automatic srrw_pkg::pkt_word_t make_packet(logic [srrw_pkg::SEQ_W-1:0] seq,
                                                        logic [srrw_pkg::SEQ_W-1:0] ack,
                                                        logic [srrw_pkg::LOW_W-1:0] lo,
                                                        logic [srrw_pkg::LOW_W-1:0] mid,
                                                        logic [srrw_pkg::HIGH_W-1:0] hi);
        srrw_pkg::pkt_word_t w;
        w.seq_number   = seq;
        w.ack_number   = ack;
        w.payload_low  = lo;
        w.payload_mid  = mid;
        w.payload_high = hi;
        w.packet_check = pkt_total(w);
        return w;
    endfunction

    function automatic srrw_pkg::pkt_word_t random_packet(logic [srrw_pkg::SEQ_W-1:0] seq);
        return make_packet(seq, srrw_pkg::SEQ_W'($urandom), {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom);
    endfunction

    function automatic void push_ack(logic [srrw_pkg::SEQ_W-1:0] seq);
        srrw_pkg::res_word_t r;
        r             = '0;
        r.result_kind = srrw_pkg::KIND_ACK;
        r.result_seq  = seq;
        r.ack_check   = {seq, 1'b0};
        r.last_of_run = 1'b1;
        expected_results.push_back(r);
        n_acks++;
    endfunction

    function automatic void predict_window(srrw_pkg::pkt_word_t w);
        logic [srrw_pkg::SEQ_W-1:0] seq_dist;
        int                         slot;
        srrw_pkg::res_word_t        r;
        n_pkts++;
        if (pkt_total(w) != w.packet_check)
        begin
            n_bad++;
            return;
        end
        seq_dist = w.seq_number - window_base;
        if (seq_dist >= WIN)
        begin
            // behind the window: already delivered, ack again; past the end: drop
            if (seq_dist[srrw_pkg::SEQ_W-1])
                push_ack(w.seq_number);
            else
                n_drop++;
            return;
        end
        slot            = w.seq_number % WIN;
        slot_full[slot] = 1'b1;
        slot_low[slot]  = w.payload_low;
        slot_mid[slot]  = w.payload_mid;
        slot_high[slot] = w.payload_high;
        push_ack(w.seq_number);
        if (seq_dist != 0)
            return;
        for (int k = 0; k < WIN; k++)
        begin
            slot = window_base % WIN;
            if (!slot_full[slot])
                break;
            r = expected_results.pop_back();
            r.last_of_run = 1'b0;
            expected_results.push_back(r);
            r             = '0;
            r.result_kind = srrw_pkg::KIND_DELIVER;
            r.result_seq  = window_base;
            r.data_low    = slot_low[slot];
            r.data_mid    = slot_mid[slot];
            r.data_high   = slot_high[slot];
            r.last_of_run = 1'b1;
            expected_results.push_back(r);
            slot_full[slot] = 1'b0;
            window_base++;
            n_deliv++;
        end
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back words
    task automatic send_packet(srrw_pkg::pkt_word_t w);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            pkt_valid <= 1'b0;
            @(negedge clk);
        end
        pkt_valid <= 1'b1;
        pkt_word  <= w;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        predict_window(w);
        @(negedge clk);
    endtask

    task automatic drain_results();
        pkt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        res_stall <= rst_n && !no_idle && ($urandom_range(99) < 13);

    function automatic void check_field(string name, logic [srrw_pkg::LOW_W-1:0] exp_val,
                                        logic [srrw_pkg::LOW_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, res_word);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", srrw_pkg::LOW_W'(want.result_kind),
                            srrw_pkg::LOW_W'(res_word.result_kind));
                check_field("result_seq", srrw_pkg::LOW_W'(want.result_seq),
                            srrw_pkg::LOW_W'(res_word.result_seq));
                check_field("ack_check", srrw_pkg::LOW_W'(want.ack_check),
                            srrw_pkg::LOW_W'(res_word.ack_check));
                check_field("data_low", want.data_low, res_word.data_low);
                check_field("data_mid", want.data_mid, res_word.data_mid);
                check_field("data_high", srrw_pkg::LOW_W'(want.data_high),
                            srrw_pkg::LOW_W'(res_word.data_high));
                check_field("last_of_run", srrw_pkg::LOW_W'(want.last_of_run),
                            srrw_pkg::LOW_W'(res_word.last_of_run));
            end
        end
    end

    task automatic test_in_order();
        send_packet(make_packet(window_base, '0, '0, '0, '0));
        send_packet(make_packet(window_base, '1, '1, '1, '1));
    endtask

    // fill the window backwards, overwrite one slot, then close the gap: 33 results
    task automatic test_full_run();
        for (int k = WIN - 1; k >= 1; k--)
            send_packet(random_packet(window_base + srrw_pkg::SEQ_W'(k)));
        send_packet(make_packet(window_base + srrw_pkg::SEQ_W'(7), 16'h5555, {32{2'b10}},
                                {32{2'b01}}, '1));
        send_packet(random_packet(window_base));
    endtask

    task automatic test_window_edges();
        // zero payload with maximal seq and ack gives the largest check value
        send_packet(make_packet('1, '1, '0, '0, '0));
        send_packet(random_packet(window_base + 16'h8000));
        send_packet(random_packet(window_base + srrw_pkg::SEQ_W'(WIN)));
        send_packet(random_packet(window_base + 16'h7FFF));
    endtask

    task automatic test_bad_check();
        srrw_pkg::pkt_word_t w;
        w = random_packet(window_base);
        w.packet_check = w.packet_check + 1'b1;
        send_packet(w);
        w = random_packet(window_base + srrw_pkg::SEQ_W'(1));
        w.packet_check = ~w.packet_check;
        send_packet(w);
    endtask

    task automatic test_random();
        srrw_pkg::pkt_word_t        w;
        int                         pick;
        logic [srrw_pkg::SEQ_W-1:0] delta;
        for (int i = 0; i < RUN_ITEMS; i++)
        begin
            no_idle = (i >= 90 && i < 140);
            if (i == 150)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 70)
                delta = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(WIN - 1));
            else if (pick < 80)
                delta = 16'($urandom_range(65535, 32768));
            else if (pick < 88)
                delta = 16'($urandom_range(32767, WIN));
            else
                delta = 16'($urandom);
            w = random_packet(window_base + delta);
            if (pick >= 88)
                w.packet_check = w.packet_check
                               ^ srrw_pkg::CHECK_W'($urandom_range(262143, 1));
            send_packet(w);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pkt_valid   = 1'b0;
        pkt_word    = '0;
        no_idle     = 1'b0;
        n_pkts      = 0;
        n_acks      = 0;
        n_deliv     = 0;
        n_drop      = 0;
        n_bad       = 0;
        window_base = '0;
        for (int i = 0; i < WIN; i++)
        begin
            slot_full[i] = 1'b0;
            slot_low[i]  = '0;
            slot_mid[i]  = '0;
            slot_high[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_in_order();
        test_full_run();
        test_window_edges();
        test_bad_check();
        test_random();

        pkt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d packets: %0d acks and %0d in-order deliveries expected,", n_pkts,
                 n_acks, n_deliv);
        $display("%0d dropped past the window end, %0d rejected on the check value.", n_drop,
                 n_bad);
        if (errors == 0)
            $display("** selective_repeat_receive_window: PASSED **");
        else
            $display("** selective_repeat_receive_window: FAILED **");
        $finish;
    end
endmodule
